### design/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; expects i_clk and i_rst_n in the scope of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge once reset is released.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error(msg);

`endif

### design/mvt_pkg.sv
// Shared types and constants of the matrix-vector transform unit.
// Depends on nothing.
package mvt_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int N_DIM         = 4;
    localparam int WORD_W        = 32;
    localparam int IDX_W         = 4;
    localparam int ROW_W         = 2;

    typedef enum logic {
        ACT_LOAD  = 1'b0,
        ACT_XFORM = 1'b1
    } t_action;

    // One input beat
    typedef struct packed {
        t_action                   action;
        logic [IDX_W-1:0]          element_index;
        logic signed [WORD_W-1:0]  element_value;
        logic signed [WORD_W-1:0]  vec_x;
        logic signed [WORD_W-1:0]  vec_y;
        logic signed [WORD_W-1:0]  vec_z;
        logic signed [WORD_W-1:0]  vec_w;
    } t_vtx_beat;

    // One result beat
    typedef struct packed {
        logic signed [WORD_W-1:0]  out_x;
        logic signed [WORD_W-1:0]  out_y;
        logic signed [WORD_W-1:0]  out_z;
        logic signed [WORD_W-1:0]  out_w;
        logic                      saturated;
    } t_res_beat;

    // Item traveling down the cell chain
    typedef struct packed {
        logic                           valid;
        t_action                        action;
        logic [IDX_W-1:0]               index;
        logic [WORD_W-1:0]              value;
        logic [N_DIM-1:0][WORD_W-1:0]   vec;
    } t_token;

endpackage

### design/mvt_stream_if.sv
// Valid/ready stream channel carrying one payload per beat.
// Depends on nothing; the payload type is set where it is instantiated.
interface mvt_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### design/matrix_vector_transform.sv
// Channel  Dir  Beat        Meaning
// i_vtx    in   t_vtx_beat  matrix element load or vector to transform
// o_res    out  t_res_beat  transformed vector and saturation flag
//
// One item per cycle while the skid register is empty; a vector, once taken,
// passes through four column cells of two stages each, then the output register;
// the first stage loads on the accepting edge.
// Loads walk the chain too, so each column sees items in arrival order.
// Reset restores the identity matrix and empties the chain.
// A stalled result moves to a skid register; i_vtx.ready drops while it is full.
// Depends on mvt_pkg, mvt_stream_if, mvt_cell and mvt_out_stage.
module matrix_vector_transform #(
    parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mvt_stream_if.sink    i_vtx,
    mvt_stream_if.source  o_res
);
    import mvt_pkg::*;

    localparam int SUM_W = 2 * WORD_W - FRAC_BITS + 2;

    logic                               w_en;
    t_token                             w_tok [N_DIM+1];
    logic signed [N_DIM-1:0][SUM_W-1:0] w_sum [N_DIM+1];
    t_res_beat                          w_beat;

    // Accepted beat enters the chain with zero row sums
    assign i_vtx.ready     = w_en;
    assign w_tok[0].valid  = i_vtx.valid && w_en;
    assign w_tok[0].action = i_vtx.payload.action;
    assign w_tok[0].index  = i_vtx.payload.element_index;
    assign w_tok[0].value  = i_vtx.payload.element_value;
    assign w_tok[0].vec    = {i_vtx.payload.vec_w, i_vtx.payload.vec_z,
                              i_vtx.payload.vec_y, i_vtx.payload.vec_x};
    assign w_sum[0]        = '0;

    // One cell per matrix column
    for (genvar c = 0; c < N_DIM; c++) begin : g_cell
        mvt_cell #(
            .FRAC_BITS (FRAC_BITS),
            .COL       (c)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_tok   (w_tok[c]),
            .i_sum   (w_sum[c]),
            .o_tok   (w_tok[c+1]),
            .o_sum   (w_sum[c+1])
        );
    end

    mvt_out_stage #(
        .FRAC_BITS (FRAC_BITS)
    ) u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (w_tok[N_DIM]),
        .i_sum   (w_sum[N_DIM]),
        .o_en    (w_en),
        .o_valid (o_res.valid),
        .i_ready (o_res.ready),
        .o_beat  (w_beat)
    );

    assign o_res.payload = w_beat;

endmodule

### design/mvt_cell.sv
// One column cell: holds a matrix column, applies loads, adds its products.
// Depends on mvt_pkg.
module mvt_cell #(
    parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF,
    parameter int COL       = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  mvt_pkg::t_token     i_tok,
    input  logic signed [mvt_pkg::N_DIM-1:0][2*mvt_pkg::WORD_W-FRAC_BITS+1:0] i_sum,
    output mvt_pkg::t_token     o_tok,
    output logic signed [mvt_pkg::N_DIM-1:0][2*mvt_pkg::WORD_W-FRAC_BITS+1:0] o_sum
);
    import mvt_pkg::*;

    localparam int PROD_W = 2 * WORD_W;
    localparam int SUM_W  = PROD_W - FRAC_BITS + 2;
    localparam logic [IDX_W-ROW_W-1:0] COL_IDX = (IDX_W-ROW_W)'(COL);
    localparam logic signed [WORD_W-1:0] ONE = {{(WORD_W-1){1'b0}}, 1'b1} << FRAC_BITS;

    logic signed [WORD_W-1:0]           r_col [N_DIM];
    logic signed [PROD_W-1:0]           w_prod [N_DIM];
    logic signed [PROD_W-1:0]           r_prod [N_DIM];
    t_token                             r_tok_a;
    t_token                             r_tok_b;
    logic signed [N_DIM-1:0][SUM_W-1:0] r_sum_a;
    logic signed [N_DIM-1:0][SUM_W-1:0] n_sum_b;
    logic signed [N_DIM-1:0][SUM_W-1:0] r_sum_b;
    logic                               w_load_hit;

    // Column store, identity column after reset
    assign w_load_hit = i_en && i_tok.valid && (i_tok.action == ACT_LOAD)
                        && (i_tok.index[IDX_W-1:ROW_W] == COL_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < N_DIM; r++) begin
                r_col[r] <= (r == COL) ? ONE : '0;
            end
        end else if (w_load_hit) begin
            r_col[i_tok.index[ROW_W-1:0]] <= $signed(i_tok.value);
        end
    end

    // Products of the column with this cell's vector component
    always_comb begin
        for (int r = 0; r < N_DIM; r++) begin
            w_prod[r] = PROD_W'(r_col[r]) * PROD_W'($signed(i_tok.vec[COL]));
        end
    end

    // Stage A: products registered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_a.valid <= 1'b0;
        end else if (i_en) begin
            r_tok_a <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum_a <= i_sum;
            for (int r = 0; r < N_DIM; r++) begin
                r_prod[r] <= w_prod[r];
            end
        end
    end

    // Stage B: floor-shifted products added to the running row sums
    always_comb begin
        for (int r = 0; r < N_DIM; r++) begin
            n_sum_b[r] = r_sum_a[r] + SUM_W'(r_prod[r] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok_b.valid <= 1'b0;
        end else if (i_en) begin
            r_tok_b <= r_tok_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sum_b <= n_sum_b;
        end
    end

    assign o_tok = r_tok_b;
    assign o_sum = r_sum_b;

endmodule

### design/mvt_out_stage.sv
// Saturation, output register and skid register of the transform unit.
// Depends on mvt_pkg.
module mvt_out_stage #(
    parameter int FRAC_BITS = mvt_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mvt_pkg::t_token     i_tok,
    input  logic signed [mvt_pkg::N_DIM-1:0][2*mvt_pkg::WORD_W-FRAC_BITS+1:0] i_sum,
    output logic                o_en,
    output logic                o_valid,
    input  logic                i_ready,
    output mvt_pkg::t_res_beat  o_beat
);
    import mvt_pkg::*;

    localparam int SUM_W = 2 * WORD_W - FRAC_BITS + 2;
    localparam int HI_W  = SUM_W - WORD_W + 1;
    localparam logic [WORD_W-1:0] S_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic [WORD_W-1:0] S_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    logic [N_DIM-1:0][WORD_W-1:0] w_val;
    logic [N_DIM-1:0]             w_clip;
    logic [HI_W-1:0]              w_hi [N_DIM];
    t_res_beat                    w_beat;
    logic                         w_res_valid;
    logic                         r_out_valid;
    t_res_beat                    r_out;
    logic                         r_skid_valid;
    t_res_beat                    r_skid;

    // Clip each row sum to the signed word range
    always_comb begin
        for (int r = 0; r < N_DIM; r++) begin
            w_hi[r] = i_sum[r][SUM_W-1:WORD_W-1];
            if ((w_hi[r] == '0) || (w_hi[r] == '1)) begin
                w_val[r]  = i_sum[r][WORD_W-1:0];
                w_clip[r] = 1'b0;
            end else begin
                w_val[r]  = i_sum[r][SUM_W-1] ? S_MIN : S_MAX;
                w_clip[r] = 1'b1;
            end
        end
    end

    assign w_beat.out_x     = $signed(w_val[0]);
    assign w_beat.out_y     = $signed(w_val[1]);
    assign w_beat.out_z     = $signed(w_val[2]);
    assign w_beat.out_w     = $signed(w_val[3]);
    assign w_beat.saturated = |w_clip;

    // Loads leave the chain here without a result
    assign w_res_valid = i_tok.valid && (i_tok.action == ACT_XFORM);

    // Chain advances while the skid register is empty
    assign o_en = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_skid_valid) begin
            if (w_res_valid) begin
                if (!r_out_valid || i_ready) begin
                    r_out_valid <= 1'b1;
                end else begin
                    r_skid_valid <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end else if (i_ready) begin
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_valid) begin
            if (w_res_valid) begin
                if (!r_out_valid || i_ready) begin
                    r_out <= w_beat;
                end else begin
                    r_skid <= w_beat;
                end
            end
        end else if (i_ready) begin
            r_out <= r_skid;
        end
    end

    assign o_valid = r_out_valid;
    assign o_beat  = r_out;

endmodule

### design/mvt_checker.sv
// Port-level checks of the transform unit, bound to its top level.
// Depends on mvt_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mvt_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_ready,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  mvt_pkg::t_res_beat i_out_beat
);
    import mvt_pkg::*;

    // Reset empties the output side
    `ASSERT_ALWAYS(a_reset_empty, !i_rst_n |=> !i_out_valid, "result valid after reset")

    // A stalled result stays offered, unchanged
    `ASSERT_CLK(a_out_hold, i_out_valid && !i_out_ready |=> i_out_valid, "result dropped")
    `ASSERT_CLK(a_out_stable, i_out_valid && !i_out_ready |=> $stable(i_out_beat),
        "result changed under stall")

    // Input backpressure only follows an output stall, with a result waiting
    `ASSERT_CLK(a_stall_cause, !i_in_ready |-> $past(i_out_valid && !i_out_ready),
        "input stalled without output stall")
    `ASSERT_CLK(a_stall_pending, !i_in_ready |-> i_out_valid, "input stalled with no result")

endmodule

bind matrix_vector_transform mvt_checker u_mvt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_vtx.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_out_beat  (o_res.payload)
);
